>>> design/pireg_pkg.sv
// Package for the PI regulator: op codes, register indexes, field widths,
// datapath command codes and the controller-to-datapath struct.
// No dependencies.
package pireg_pkg;

    localparam int INTEGRAL_BITS_DEF = 40;

    localparam int WORD_W   = 32;
    localparam int LIMIT_W  = 31;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_STEP   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADJUST = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT  = 2'd3;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_NOP,
        DP_MUL_KT,
        DP_MUL_PK,
        DP_MUL_INC,
        DP_RND_INC,
        DP_ADD_CAND,
        DP_ADD_PK,
        DP_ADD_FF,
        DP_DECIDE,
        DP_AUX
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
        logic    publish;
    } pireg_ctl_t;

endpackage

>>> design/pireg_if.sv
// Channel interfaces of the PI regulator: request, response and register write.
// Depends on pireg_pkg.
interface pireg_req_if
    import pireg_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] error_in;
    logic signed [WORD_W-1:0] feed_forward;
    logic signed [WORD_W-1:0] adjust_value;

    modport source (output valid, op, error_in, feed_forward, adjust_value, input ready);
    modport sink (input valid, op, error_in, feed_forward, adjust_value, output ready);
endinterface

interface pireg_rsp_if
    import pireg_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] drive;
    logic                     saturated;

    modport source (output valid, drive, saturated, input ready);
    modport sink (input valid, drive, saturated, output ready);
endinterface

interface pireg_cfg_if
    import pireg_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [WORD_W-1:0]    wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

>>> design/pireg_ctrl.sv
// Sequencer of the PI regulator: steps the datapath through one word and
// holds the response valid flag. Depends on pireg_pkg.
module pireg_ctrl
    import pireg_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic [OP_W-1:0] req_op,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output pireg_ctl_t      ctl
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_KT,
        ST_MUL_PK,
        ST_MUL_INC,
        ST_RND_INC,
        ST_ADD_CAND,
        ST_ADD_PK,
        ST_ADD_FF,
        ST_DECIDE,
        ST_AUX,
        ST_PUBLISH
    } state_t;

    state_t  state_reg;
    dp_cmd_t cmd_reg;
    logic    out_valid_reg;
    logic    publish;

    assign req_ready   = (state_reg == ST_IDLE);
    assign rsp_valid   = out_valid_reg;
    assign publish     = (state_reg == ST_PUBLISH) && (!out_valid_reg || rsp_ready);
    assign ctl.cmd     = cmd_reg;
    assign ctl.publish = publish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= DP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req_op == OP_STEP)
                        begin
                            state_reg <= ST_MUL_KT;
                            cmd_reg   <= DP_MUL_KT;
                        end
                        else
                        begin
                            state_reg <= ST_AUX;
                            cmd_reg   <= DP_AUX;
                        end
                    end
                end
                ST_MUL_KT:
                begin
                    state_reg <= ST_MUL_PK;
                    cmd_reg   <= DP_MUL_PK;
                end
                ST_MUL_PK:
                begin
                    state_reg <= ST_MUL_INC;
                    cmd_reg   <= DP_MUL_INC;
                end
                ST_MUL_INC:
                begin
                    state_reg <= ST_RND_INC;
                    cmd_reg   <= DP_RND_INC;
                end
                ST_RND_INC:
                begin
                    state_reg <= ST_ADD_CAND;
                    cmd_reg   <= DP_ADD_CAND;
                end
                ST_ADD_CAND:
                begin
                    state_reg <= ST_ADD_PK;
                    cmd_reg   <= DP_ADD_PK;
                end
                ST_ADD_PK:
                begin
                    state_reg <= ST_ADD_FF;
                    cmd_reg   <= DP_ADD_FF;
                end
                ST_ADD_FF:
                begin
                    state_reg <= ST_DECIDE;
                    cmd_reg   <= DP_DECIDE;
                end
                ST_DECIDE, ST_AUX:
                begin
                    state_reg <= ST_PUBLISH;
                    cmd_reg   <= DP_NOP;
                end
                ST_PUBLISH:
                begin
                    if (publish)
                    begin
                        state_reg <= ST_IDLE;
                        cmd_reg   <= DP_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    cmd_reg   <= DP_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/pireg_dp.sv
// Datapath of the PI regulator: gain registers, shared 33x33 multiplier,
// integral state, saturating adders and the output clamp. Depends on pireg_pkg.
module pireg_dp
    import pireg_pkg::*;
#(
    parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pireg_ctl_t               ctl,
    input  logic [OP_W-1:0]          op,
    input  logic signed [WORD_W-1:0] error_in,
    input  logic signed [WORD_W-1:0] feed_forward,
    input  logic signed [WORD_W-1:0] adjust_value,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    output logic                     cfg_ready,
    output logic signed [WORD_W-1:0] drive,
    output logic                     saturated
);

    localparam int IB   = INTEGRAL_BITS;
    localparam int SW   = 66;
    localparam int MW   = 33;
    localparam int TW   = 48;

    localparam logic signed [SW-1:0] IB_MAX  = {{(SW-IB+1){1'b0}}, {(IB-1){1'b1}}};
    localparam logic signed [SW-1:0] IB_MIN  = ~IB_MAX;
    localparam logic signed [SW-1:0] S64_MAX = {{(SW-63){1'b0}}, {63{1'b1}}};
    localparam logic signed [SW-1:0] S64_MIN = ~S64_MAX;
    localparam logic signed [SW-1:0] S32_MAX = {{(SW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SW-1:0] S32_MIN = ~S32_MAX;

    function automatic logic signed [IB-1:0] sat_ib(input logic signed [SW-1:0] v);
        if (v > IB_MAX)
            sat_ib = IB_MAX[IB-1:0];
        else if (v < IB_MIN)
            sat_ib = IB_MIN[IB-1:0];
        else
            sat_ib = v[IB-1:0];
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [SW-1:0] v);
        if (v > S64_MAX)
            sat64 = S64_MAX[63:0];
        else if (v < S64_MIN)
            sat64 = S64_MIN[63:0];
        else
            sat64 = v[63:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SW-1:0] v);
        if (v > S32_MAX)
            sat32 = S32_MAX[WORD_W-1:0];
        else if (v < S32_MIN)
            sat32 = S32_MIN[WORD_W-1:0];
        else
            sat32 = v[WORD_W-1:0];
    endfunction

    // Q16.16 product rounded half up, floor shift
    function automatic logic signed [TW-1:0] rnd16(input logic signed [SW-1:0] p);
        logic signed [SW-1:0] t;
        t = p + 66'sd32768;
        rnd16 = t[63:16];
    endfunction

    logic [WORD_W-1:0]          prop_gain_reg;
    logic [WORD_W-1:0]          integ_gain_reg;
    logic [WORD_W-1:0]          sample_period_reg;
    logic [LIMIT_W-1:0]         limit_reg;
    logic signed [IB-1:0]       integ_reg;

    logic [OP_W-1:0]            op_reg;
    logic signed [WORD_W-1:0]   err_reg;
    logic signed [WORD_W-1:0]   ff_reg;
    logic signed [WORD_W-1:0]   adj_reg;
    logic signed [SW-1:0]       prod_reg;
    logic [WORD_W-1:0]          kt_reg;
    logic signed [TW-1:0]       pk_reg;
    logic signed [TW-1:0]       inc_reg;
    logic signed [IB-1:0]       cand_reg;
    logic signed [63:0]         sum_reg;
    logic signed [WORD_W-1:0]   res_drive_reg;
    logic                       res_sat_reg;
    logic signed [WORD_W-1:0]   drive_reg;
    logic                       sat_reg;

    logic signed [MW-1:0]       mul_a;
    logic signed [MW-1:0]       mul_b;
    logic signed [SW-1:0]       kt_sum;
    logic signed [SW-1:0]       integ_ext;
    logic signed [SW-1:0]       cand_ext;
    logic signed [63:0]         lim64;
    logic signed [63:0]         nlim64;
    logic                       over_hi;
    logic                       under_lo;
    logic                       same_sign;

    assign cfg_ready = 1'b1;
    assign drive     = drive_reg;
    assign saturated = sat_reg;

    assign kt_sum    = prod_reg + 66'sd2147483648;
    assign integ_ext = {{(SW-IB){integ_reg[IB-1]}}, integ_reg};
    assign cand_ext  = {{(SW-IB){cand_reg[IB-1]}}, cand_reg};
    assign lim64     = {{(64-LIMIT_W){1'b0}}, limit_reg};
    assign nlim64    = 64'sd0 - lim64;
    assign over_hi   = sum_reg > lim64;
    assign under_lo  = sum_reg < nlim64;
    assign same_sign = ((sum_reg > 64'sd0) && (err_reg > 32'sd0))
                    || ((sum_reg < 64'sd0) && (err_reg < 32'sd0));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.cmd)
            DP_MUL_KT:
            begin
                mul_a = {1'b0, integ_gain_reg};
                mul_b = {1'b0, sample_period_reg};
            end
            DP_MUL_PK:
            begin
                mul_a = {1'b0, prop_gain_reg};
                mul_b = {err_reg[WORD_W-1], err_reg};
            end
            DP_MUL_INC:
            begin
                mul_a = {1'b0, kt_reg};
                mul_b = {err_reg[WORD_W-1], err_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // registers and integral
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            sample_period_reg <= '0;
            limit_reg         <= '1;
            integ_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                    CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_data;
                    CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                    CFG_OUTPUT_LIMIT:  limit_reg         <= cfg_data[LIMIT_W-1:0];
                    default:           ;
                endcase
            end
            case (ctl.cmd)
                DP_DECIDE:
                begin
                    if (!((over_hi || under_lo) && same_sign))
                    begin
                        integ_reg <= cand_reg;
                    end
                end
                DP_AUX:
                begin
                    case (op_reg)
                        OP_ADJUST:
                            integ_reg <= sat_ib(integ_ext
                                + {{(SW-WORD_W){adj_reg[WORD_W-1]}}, adj_reg});
                        OP_CLEAR:
                            integ_reg <= '0;
                        default:
                            ;
                    endcase
                end
                default:
                    ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (ctl.cmd)
            DP_IDLE:
            begin
                op_reg  <= op;
                err_reg <= error_in;
                ff_reg  <= feed_forward;
                adj_reg <= adjust_value;
            end
            DP_MUL_PK:
                kt_reg <= kt_sum[63:32];
            DP_MUL_INC:
                pk_reg <= rnd16(prod_reg);
            DP_RND_INC:
                inc_reg <= rnd16(prod_reg);
            DP_ADD_CAND:
                cand_reg <= sat_ib(integ_ext + {{(SW-TW){inc_reg[TW-1]}}, inc_reg});
            DP_ADD_PK:
                sum_reg <= sat64(cand_ext + {{(SW-TW){pk_reg[TW-1]}}, pk_reg});
            DP_ADD_FF:
                sum_reg <= sat64({{(SW-64){sum_reg[63]}}, sum_reg}
                    + {{(SW-WORD_W){ff_reg[WORD_W-1]}}, ff_reg});
            DP_DECIDE:
            begin
                res_sat_reg <= over_hi || under_lo;
                if (over_hi)
                    res_drive_reg <= lim64[WORD_W-1:0];
                else if (under_lo)
                    res_drive_reg <= nlim64[WORD_W-1:0];
                else
                    res_drive_reg <= sum_reg[WORD_W-1:0];
            end
            default:
                ;
        endcase
        if (ctl.publish)
        begin
            if (op_reg == OP_STEP)
            begin
                drive_reg <= res_drive_reg;
                sat_reg   <= res_sat_reg;
            end
            else
            begin
                drive_reg <= sat32(integ_ext);
                sat_reg   <= 1'b0;
            end
        end
    end

endmodule

>>> design/pi_regulator_conditional_integration.sv
// PI regulator with feed-forward, output clamp and conditional integration.
// Regulator step: states MUL_KT, MUL_PK, MUL_INC, RND_INC, ADD_CAND, ADD_PK, ADD_FF,
// DECIDE, PUBLISH; adjust/clear ops run AUX, PUBLISH. Requests are taken in IDLE.
// The shared 33x33 multiplier (three products per step) sets the step length.
// A request is taken while the previous response still waits in the output register.
// Async active-low reset: gains and period 0, limit full scale, integral 0.
module pi_regulator_conditional_integration
    import pireg_pkg::*;
#(
    parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    pireg_req_if.sink   request,
    pireg_rsp_if.source response,
    pireg_cfg_if.sink   cfg
);

    pireg_ctl_t               ctl;
    logic signed [WORD_W-1:0] drive;
    logic                     saturated;

    pireg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_op    (request.op),
        .req_ready (request.ready),
        .rsp_valid (response.valid),
        .rsp_ready (response.ready),
        .ctl       (ctl)
    );

    pireg_dp #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .op           (request.op),
        .error_in     (request.error_in),
        .feed_forward (request.feed_forward),
        .adjust_value (request.adjust_value),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.reg_index),
        .cfg_data     (cfg.wr_data),
        .cfg_ready    (cfg.ready),
        .drive        (drive),
        .saturated    (saturated)
    );

    assign response.drive     = drive;
    assign response.saturated = saturated;

endmodule

>>> dv/pireg_checker.sv
// Checker for the PI regulator: watches request, response and register write
// channels, predicts every response word and compares it field by field.
// Depends on pireg_pkg and the channel interfaces in pireg_if.sv.
`timescale 1ns / 100ps

module pireg_checker
    import pireg_pkg::*;
#(
    parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    pireg_req_if  request,
    pireg_rsp_if  response,
    pireg_cfg_if  cfg,
    output int    errors,
    output int    outstanding,
    output int    words_checked,
    output int    clamp_count
);

    typedef logic signed [79:0] wide_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] drive;
        logic                     saturated;
    } drive_word_t;

    localparam wide_t SAT64_HI = (wide_t'(1) <<< 63) - 1;
    localparam wide_t SAT64_LO = -(wide_t'(1) <<< 63);
    localparam wide_t INTEG_HI = (wide_t'(1) <<< (INTEGRAL_BITS - 1)) - 1;
    localparam wide_t INTEG_LO = -(wide_t'(1) <<< (INTEGRAL_BITS - 1));
    localparam wide_t DRV_HI   = (wide_t'(1) <<< 31) - 1;
    localparam wide_t DRV_LO   = -(wide_t'(1) <<< 31);

    logic [WORD_W-1:0]  kp_q;
    logic [WORD_W-1:0]  ki_q;
    logic [WORD_W-1:0]  ts_q;
    logic [LIMIT_W-1:0] lim_q;
    wide_t              integ;
    drive_word_t        pending_drives[$];

    function automatic wide_t sat64(wide_t v);
        if (v > SAT64_HI)
            return SAT64_HI;
        if (v < SAT64_LO)
            return SAT64_LO;
        return v;
    endfunction

    function automatic wide_t clamp_integ(wide_t v);
        if (v > INTEG_HI)
            return INTEG_HI;
        if (v < INTEG_LO)
            return INTEG_LO;
        return v;
    endfunction

    function automatic logic signed [WORD_W-1:0] clamp32(wide_t v);
        if (v > DRV_HI)
            return 32'h7FFF_FFFF;
        if (v < DRV_LO)
            return 32'h8000_0000;
        return v[WORD_W-1:0];
    endfunction

    // unsigned Q16.16 gain times signed Q16.16 value, rounded half up
    function automatic wide_t scale(logic [WORD_W-1:0] gain, logic signed [WORD_W-1:0] x);
        wide_t g;
        wide_t xs;
        wide_t prod;
        g = '0;
        g[WORD_W-1:0] = gain;
        xs = x;
        prod = g * xs;
        return (prod + wide_t'(32768)) >>> 16;
    endfunction

    function automatic drive_word_t regulate(logic [OP_W-1:0] op,
                                             logic signed [WORD_W-1:0] err,
                                             logic signed [WORD_W-1:0] ff,
                                             logic signed [WORD_W-1:0] adj);
        logic [63:0]       gain_prod;
        logic [WORD_W-1:0] kt;
        wide_t             e;
        wide_t             f;
        wide_t             a;
        wide_t             cand;
        wide_t             total;
        wide_t             lim;
        drive_word_t       res;
        e = err;
        f = ff;
        a = adj;
        res.saturated = 1'b0;
        if (op == OP_STEP)
        begin
            gain_prod = 64'(ki_q) * 64'(ts_q) + 64'h8000_0000;
            kt = gain_prod[63:32];
            cand = clamp_integ(sat64(integ + scale(kt, err)));
            total = sat64(sat64(cand + scale(kp_q, err)) + f);
            lim = '0;
            lim[LIMIT_W-1:0] = lim_q;
            if (total > lim || total < -lim)
            begin
                res.saturated = 1'b1;
                res.drive = (total > lim) ? 32'(lim) : 32'(-lim);
                // conditional integration: drop the step when pushing further out
                if (!((total > 0 && e > 0) || (total < 0 && e < 0)))
                    integ = cand;
                clamp_count++;
            end
            else
            begin
                res.drive = total[WORD_W-1:0];
                integ = cand;
            end
        end
        else
        begin
            if (op == OP_ADJUST)
                integ = clamp_integ(sat64(integ + a));
            else if (op == OP_CLEAR)
                integ = '0;
            res.drive = clamp32(integ);
        end
        return res;
    endfunction

    task automatic log_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_word_t want;
        if (!rst_n)
        begin
            kp_q = '0;
            ki_q = '0;
            ts_q = '0;
            lim_q = '1;
            integ = '0;
            pending_drives.delete();
            outstanding = 0;
        end
        else
        begin
            if (response.valid && response.ready)
            begin
                if (pending_drives.size() == 0)
                    log_mismatch($sformatf("response word with none expected, drive %0d",
                                           response.drive));
                else
                begin
                    want = pending_drives.pop_front();
                    if (response.drive !== want.drive)
                        log_mismatch($sformatf("drive %0d, expected %0d",
                                               response.drive, want.drive));
                    if (response.saturated !== want.saturated)
                        log_mismatch($sformatf("saturated %0b, expected %0b",
                                               response.saturated, want.saturated));
                    words_checked++;
                end
            end
            if (request.valid && request.ready)
                pending_drives.push_back(regulate(request.op, request.error_in,
                                                  request.feed_forward, request.adjust_value));
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    CFG_PROP_GAIN:     kp_q = cfg.wr_data;
                    CFG_INTEG_GAIN:    ki_q = cfg.wr_data;
                    CFG_SAMPLE_PERIOD: ts_q = cfg.wr_data;
                    CFG_OUTPUT_LIMIT:  lim_q = cfg.wr_data[LIMIT_W-1:0];
                    default:           ;
                endcase
            end
            outstanding = pending_drives.size();
        end
    end

endmodule

>>> dv/pi_regulator_conditional_integration_tb.sv
// Testbench top for the PI regulator: clock, reset, request/register stimulus,
// random response back-pressure, watchdog and verdict.
// Depends on pireg_pkg, pireg_if.sv, the regulator RTL and pireg_checker.
`timescale 1ns / 100ps

module pi_regulator_conditional_integration_tb;
    import pireg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 100;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int errors;
    int outstanding;
    int words_checked;
    int clamp_count;
    int idle_cycles = 0;
    int words_sent = 0;
    int cfg_writes = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    pireg_req_if request();
    pireg_rsp_if response();
    pireg_cfg_if cfg();

    pi_regulator_conditional_integration #(
        .INTEGRAL_BITS(INTEGRAL_BITS_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .cfg      (cfg)
    );

    pireg_checker #(
        .INTEGRAL_BITS(INTEGRAL_BITS_DEF)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .response      (response),
        .cfg           (cfg),
        .errors        (errors),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .clamp_count   (clamp_count)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 8)) - 32'd4;
            3, 4: return $urandom;
            default:
            begin
                w = $urandom >> $urandom_range(4, 24);
                if ($urandom_range(0, 1))
                    w = -w;
                return w;
            end
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_period();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            3: return $urandom >> 1;
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wr_data <= data;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg_writes++;
    endtask

    task automatic load_gains(logic [WORD_W-1:0] kp, logic [WORD_W-1:0] ki,
                              logic [WORD_W-1:0] ts, logic [WORD_W-1:0] lim);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_SAMPLE_PERIOD, ts);
        write_reg(CFG_OUTPUT_LIMIT, lim);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_word(logic [OP_W-1:0] op, logic [WORD_W-1:0] err,
                             logic [WORD_W-1:0] ff, logic [WORD_W-1:0] adj);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            request.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request.valid <= 1'b1;
        request.op <= op;
        request.error_in <= err;
        request.feed_forward <= ff;
        request.adjust_value <= adj;
        do @(posedge clk); while (!request.ready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_random();
        int r;
        logic [OP_W-1:0] op;
        r = $urandom_range(0, 99);
        if (r < 72)
            op = OP_STEP;
        else if (r < 84)
            op = OP_ADJUST;
        else if (r < 92)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        send_word(op, pick_word(), pick_word(), pick_word());
    endtask

    // drive the integral into its saturation with large same-sign adds
    task automatic windup_burst(bit negative);
        logic [WORD_W-1:0] w;
        send_word(OP_CLEAR, pick_word(), pick_word(), pick_word());
        repeat (270)
        begin
            w = $urandom_range(32'h7F00_0000, 32'h7FFF_FFFF);
            if (negative)
                w = ~w;
            send_word(OP_ADJUST, pick_word(), pick_word(), w);
            if ($urandom_range(0, 15) == 0)
                send_word(OP_STEP, pick_word(), pick_word(), pick_word());
        end
        send_word(OP_UNUSED, pick_word(), pick_word(), pick_word());
        repeat (6) send_word(OP_STEP, pick_word(), pick_word(), pick_word());
    endtask

    task automatic settle();
        request.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (12) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (request.valid && request.ready) || (response.valid && response.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     WATCHDOG_LIMIT, outstanding);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : sink_side
        int stall_left;
        stall_left = 0;
        response.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0 && $urandom_range(0, 2) == 0)
                stall_left = gap_len();
            if (stall_left > 0)
            begin
                response.ready <= 1'b0;
                stall_left--;
            end
            else
                response.ready <= 1'b1;
        end
    end

    initial
    begin : source_side
        request.valid = 1'b0;
        request.op = OP_STEP;
        request.error_in = '0;
        request.feed_forward = '0;
        request.adjust_value = '0;
        cfg.valid = 1'b0;
        cfg.reg_index = CFG_PROP_GAIN;
        cfg.wr_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset gains: zero gains, full-scale limit
        send_word(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_word(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_UNUSED, 32'h0, 32'h0, 32'h7FFF_FFFF);
        settle();

        load_gains(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_STEP, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_word(OP_STEP, 32'h8000_0000, 32'h0, 32'h0);
        send_word(OP_STEP, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_STEP, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_word(OP_ADJUST, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_word(OP_UNUSED, 32'h0, 32'h0, 32'h0);
        send_word(OP_ADJUST, 32'h0, 32'h0, 32'h8000_0000);
        send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        settle();

        // zero limit
        load_gains(32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_STEP, 32'h0, 32'h0, 32'h0);
        send_word(OP_STEP, 32'h1, 32'h5, 32'h0);
        send_word(OP_STEP, 32'hFFFF_0000, 32'h0000_0100, 32'h0);
        settle();

        // full-scale gains; limit written with bit 31 set
        load_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_STEP, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_word(OP_STEP, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_word(OP_STEP, 32'h0, 32'h7FFF_FFFF, 32'h0);
        send_word(OP_ADJUST, 32'h0, 32'h0, 32'h1234_5678);
        send_word(OP_STEP, 32'hFFFF_FFFF, 32'h0, 32'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            quiet = (p == 3);
            load_gains(pick_gain(), pick_gain(), pick_period(), pick_limit());
            if (p == 2 || p == 5)
                windup_burst(p == 5);
            if (p == 4)
            begin
                // response side stalls long while words keep coming
                hold_req = 1'b1;
                repeat (12) send_word(OP_STEP, pick_word(), pick_word(), pick_word());
            end
            repeat (PHASE_WORDS) send_random();
        end
        quiet = 1'b0;
        settle();

        $display("covered %0d request words and %0d checked responses (%0d clamped steps)",
                 words_sent, words_checked, clamp_count);
        $display("across %0d register writes, two integral wind-up runs and one long stall",
                 cfg_writes);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> pi_regulator_conditional_integration.f
design/pireg_pkg.sv
design/pireg_if.sv
design/pireg_ctrl.sv
design/pireg_dp.sv
design/pi_regulator_conditional_integration.sv
dv/pireg_checker.sv
dv/pi_regulator_conditional_integration_tb.sv
